[src/bsfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_pkg
// Shared types, constants and helpers for the bit-shifted frame packer.
// ----------------------------------------------------------------------------
package bsfp_pkg;

  // item kind carried on the input channel
  typedef enum logic {
    ACT_HEADER = 1'b0,
    ACT_DATA   = 1'b1
  } action_e;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned TtlW     = 4;
  localparam int unsigned LenW     = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PendW    = 6;
  localparam int unsigned SumW     = 11;
  localparam int unsigned PopW     = 4;

  // output queue geometry: room for the three words one item can produce
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCntW    = 3;
  localparam int unsigned MaxPush  = 3;

  typedef logic [CmdW-1:0]  cmd_t;
  typedef logic [TtlW-1:0]  ttl_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PendW-1:0] pend_t;
  typedef logic [SumW-1:0]  sum_t;

  // one queued output word
  typedef struct packed {
    byte_t frame_byte;
    logic  frame_end;
  } out_word_t;

  // population count of one byte
  function automatic logic [PopW-1:0] pop8(input byte_t v);
    logic [PopW-1:0] c;
    c = '0;
    for (int i = 0; i < ByteW; i++) begin
      c = c + PopW'(v[i]);
    end
    return c;
  endfunction

endpackage

[src/bsfp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_in_if / bsfp_out_if
// Valid/ready channels carrying packer input items and packed frame words.
// ----------------------------------------------------------------------------
interface bsfp_in_if;
  import bsfp_pkg::*;

  logic    valid;
  logic    ready;
  action_e action;
  cmd_t    cmd;
  ttl_t    ttl;
  len_t    frame_length;
  byte_t   data_byte;

  modport source (output valid, action, cmd, ttl, frame_length, data_byte, input ready);
  modport sink   (input valid, action, cmd, ttl, frame_length, data_byte, output ready);
endinterface

interface bsfp_out_if;
  import bsfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

[src/bit_shifted_frame_packer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_shifted_frame_packer_unit
// Packs header and data items into a bit-shifted byte frame with a
// popcount checksum tail, through a four-word output queue.
// ----------------------------------------------------------------------------
// Each accepted item writes its frame words into the registered output queue.
// Throughput: one item per cycle while the output drains one word per cycle;
//   an item that closes a frame queues three words, so input ready drops behind
//   it until the queue holds at most one word again.
// Reset: asynchronous, clears the frame state and empties the output queue.
module bit_shifted_frame_packer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsfp_in_if.sink    in_i,
  bsfp_out_if.source out_o
);
  import bsfp_pkg::*;

  // frame state
  pend_t pend_q, pend_d;
  sum_t  sum_q, sum_d;
  len_t  left_q, left_d;
  logic  in_frame_q, in_frame_d;

  // output queue
  out_word_t           q_mem_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]    cnt_q, cnt_d;

  logic                in_acc, out_acc;
  logic [1:0]          n_push;
  out_word_t           push_w [MaxPush];
  byte_t               first_b;
  sum_t                sum1, sum2;
  pend_t               pend_new;
  len_t                left_new;
  logic                close_w;

  // handshake
  assign in_i.ready = (cnt_q <= QCntW'(QDepth - MaxPush));
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_acc    = out_o.valid & out_o.ready;
  assign out_o.frame_byte = q_mem_q[rd_ptr_q].frame_byte;
  assign out_o.frame_end  = q_mem_q[rd_ptr_q].frame_end;

  // item processing: first word, then optional checksum tail
  always_comb begin
    first_b  = '0;
    sum1     = sum_q;
    pend_new = pend_q;
    left_new = left_q;
    close_w  = 1'b0;
    n_push   = 2'd0;
    if (in_i.action == ACT_HEADER) begin
      first_b  = {in_i.frame_length[0], in_i.ttl, in_i.cmd};
      sum1     = SumW'(pop8(first_b));
      pend_new = in_i.frame_length[LenW-1:1];
      left_new = in_i.frame_length;
      close_w  = (in_i.frame_length == '0);
      n_push   = 2'd1;
    end else if (in_frame_q) begin
      first_b  = {in_i.data_byte[1:0], pend_q};
      sum1     = sum_q + SumW'(pop8(first_b));
      pend_new = in_i.data_byte[ByteW-1:2];
      left_new = left_q - LenW'(1);
      close_w  = (left_q == LenW'(1));
      n_push   = 2'd1;
    end
    sum2 = sum1 + SumW'(pop8({2'b00, pend_new}));

    push_w[0] = '{frame_byte: first_b, frame_end: 1'b0};
    push_w[1] = '{frame_byte: {sum2[1:0], pend_new}, frame_end: 1'b0};
    push_w[2] = '{frame_byte: sum2[9:2], frame_end: 1'b1};
    if (close_w) begin
      n_push = 2'd3;
    end

    // next state
    pend_d     = pend_q;
    sum_d      = sum_q;
    left_d     = left_q;
    in_frame_d = in_frame_q;
    if (in_acc && n_push != 2'd0) begin
      if (close_w) begin
        pend_d     = '0;
        sum_d      = sum2;
        left_d     = '0;
        in_frame_d = 1'b0;
      end else begin
        pend_d     = pend_new;
        sum_d      = sum1;
        left_d     = left_new;
        in_frame_d = 1'b1;
      end
    end

    cnt_d = cnt_q + (in_acc ? QCntW'(n_push) : '0) - QCntW'(out_acc);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      sum_q      <= '0;
      left_q     <= '0;
      in_frame_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      pend_q     <= pend_d;
      sum_q      <= sum_d;
      left_q     <= left_d;
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPush; i++) begin
      if (in_acc && (2'(i) < n_push)) begin
        q_mem_q[wr_ptr_q + QPtrW'(i)] <= push_w[i];
      end
    end
  end

  // checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("output queue count out of range");

  a_closed_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (left_q == '0 && pend_q == '0))
    else $error("closed frame holds leftover state");

  a_hdr_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.action == ACT_HEADER) |=>
      (in_frame_q == ($past(in_i.frame_length) != '0)))
    else $error("header did not set frame state");

  a_last_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.action == ACT_DATA && in_frame_q && left_q == LenW'(1)) |=>
      (!in_frame_q && cnt_q >= QCntW'(MaxPush)))
    else $error("last data word did not close the frame");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit-shifted frame packer. A short table of
// header and data words, then random frames, are pushed through the input
// channel. Expected frame bytes come from the table or from a predictor that
// is kept in step with every accepted word. The input side and the output
// side both stall at random, with periodic long output hold-offs and full drains.
// ----------------------------------------------------------------------------
module tb_top;
  import bsfp_pkg::*;

  localparam int unsigned LiveWords = 310;
  localparam int unsigned ErrShow   = 10;

  // one input word as seen on the channel
  typedef struct {
    action_e action;
    cmd_t    cmd;
    ttl_t    ttl;
    len_t    len;
    byte_t   data;
  } pack_item_t;

  // directed table entry: n_out < 0 means the predictor supplies the bytes
  typedef struct {
    pack_item_t  item;
    int          n_out;
    logic [26:0] out_bits;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bsfp_in_if  in_if ();
  bsfp_out_if out_if ();

  bit_shifted_frame_packer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  pend_t pk_pending;
  sum_t  pk_sum;
  len_t  pk_left;
  logic  pk_open;

  out_word_t frame_words[$];
  out_word_t frame_exp_q[$];
  dir_row_t  dir_tab[$];
  int        err_cnt;
  bit        no_gap;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= ErrShow) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // frame byte that counts toward the checksum
  function automatic void emit_counted(input byte_t b);
    out_word_t w;
    pk_sum = pk_sum + sum_t'($countones(b));
    w.frame_byte = b;
    w.frame_end  = 1'b0;
    frame_words.push_back(w);
  endfunction

  // checksum tail: low bits with the pending bits, then the high byte
  function automatic void close_tail();
    logic [9:0] cs;
    out_word_t  w;
    pk_sum = pk_sum + sum_t'($countones(pk_pending));
    cs = pk_sum[9:0];
    w.frame_byte = {cs[1:0], pk_pending};
    w.frame_end  = 1'b0;
    frame_words.push_back(w);
    w.frame_byte = cs[9:2];
    w.frame_end  = 1'b1;
    frame_words.push_back(w);
    pk_pending = '0;
    pk_left    = '0;
    pk_open    = 1'b0;
  endfunction

  // advance the predictor by one accepted word, results in frame_words
  function automatic void pack_predict(input pack_item_t it);
    frame_words.delete();
    if (it.action == ACT_HEADER) begin
      // a header always restarts, an open frame is dropped without its tail
      pk_sum = '0;
      emit_counted({it.len[0], it.ttl, it.cmd});
      pk_pending = it.len[6:1];
      pk_left    = it.len;
      pk_open    = 1'b1;
      if (it.len == '0) close_tail();
    end else if (pk_open && pk_left != '0) begin
      emit_counted({it.data[1:0], pk_pending});
      pk_pending = it.data[7:2];
      pk_left    = pk_left - 1'b1;
      if (pk_left == '0) close_tail();
    end
  endfunction

  function automatic void add_row(input action_e a, input cmd_t c, input ttl_t t,
                                  input len_t l, input byte_t d, input int n,
                                  input logic [26:0] bits);
    dir_row_t r;
    r.item.action = a;
    r.item.cmd    = c;
    r.item.ttl    = t;
    r.item.len    = l;
    r.item.data   = d;
    r.n_out       = n;
    r.out_bits    = bits;
    dir_tab.push_back(r);
  endfunction

  // offer one word, wait for its handshake, queue the bytes it causes
  task automatic send_item(input pack_item_t it, input int n_typed,
                           input logic [26:0] typed_bits, output int n_words);
    while (!no_gap && $urandom_range(0, 99) < 38) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= it.action;
    in_if.cmd          <= it.cmd;
    in_if.ttl          <= it.ttl;
    in_if.frame_length <= it.len;
    in_if.data_byte    <= it.data;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pack_predict(it);
    n_words = frame_words.size();
    if (n_typed < 0) begin
      foreach (frame_words[i]) frame_exp_q.push_back(frame_words[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        frame_exp_q.push_back(out_word_t'(typed_bits[26-9*i -: 9]));
      end
    end
  endtask

  // stop offering until every expected byte has come out
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (frame_exp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic pack_item_t rand_item(input action_e a);
    pack_item_t it;
    it.action = a;
    it.cmd    = cmd_t'($urandom);
    it.ttl    = ttl_t'($urandom);
    it.len    = len_t'($urandom);
    it.data   = byte_t'($urandom);
    return it;
  endfunction

  // output side: random stalls, with a periodic long hold-off and stretch always ready
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if ((cyc % 700) >= 150 && (cyc % 700) < 210) begin
        out_if.ready <= 1'b0;
      end else if ((cyc % 700) >= 350 && (cyc % 700) < 500) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // compare every output word with the oldest expected byte
  always @(posedge clk_i) begin
    out_word_t w;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (frame_exp_q.size() == 0) begin
        note_error($sformatf("unexpected word byte=%02h end=%0b",
                             out_if.frame_byte, out_if.frame_end));
      end else begin
        w = frame_exp_q.pop_front();
        if (out_if.frame_byte !== w.frame_byte) begin
          note_error($sformatf("frame_byte exp=%02h got=%02h",
                               w.frame_byte, out_if.frame_byte));
        end
        if (out_if.frame_end !== w.frame_end) begin
          note_error($sformatf("frame_end exp=%0b got=%0b",
                               w.frame_end, out_if.frame_end));
        end
      end
    end
  end

  // main sequence
  initial begin
    pack_item_t it;
    int         n_words;
    int         live_cnt;
    int         r;
    int         n_data;
    bit         drained_mid;

    err_cnt     = 0;
    no_gap      = 1'b0;
    live_cnt    = 0;
    drained_mid = 1'b0;
    pk_pending  = '0;
    pk_sum      = '0;
    pk_left     = '0;
    pk_open     = 1'b0;

    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_HEADER;
    in_if.cmd          <= '0;
    in_if.ttl          <= '0;
    in_if.frame_length <= '0;
    in_if.data_byte    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_row(ACT_DATA,   3'd5, 4'd9,  7'd77,  8'hFF, 0, '0);          // data before any frame
    add_row(ACT_HEADER, 3'd7, 4'd15, 7'd0,   8'h5A, 3,
            {8'h7F, 1'b0, 8'hC0, 1'b0, 8'h01, 1'b1});                // all ones, empty frame
    add_row(ACT_DATA,   3'd0, 4'd0,  7'd127, 8'hA5, 0, '0);          // data after a closed frame
    add_row(ACT_HEADER, 3'd0, 4'd0,  7'd0,   8'hFF, 3,
            {8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1});                // all zeros, empty frame
    add_row(ACT_HEADER, 3'd0, 4'd0,  7'd127, 8'h00, 1, {8'h80, 1'b0, 18'd0});
    add_row(ACT_DATA,   3'd7, 4'd15, 7'd0,   8'hFF, 1, {8'hFF, 1'b0, 18'd0});
    add_row(ACT_DATA,   3'd2, 4'd6,  7'd33,  8'h00, 1, {8'h3F, 1'b0, 18'd0});
    add_row(ACT_DATA,   3'd1, 4'd1,  7'd1,   8'h03, -1, '0);
    // header while a frame is open drops the old one
    add_row(ACT_HEADER, 3'd5, 4'd10, 7'd1,   8'h99, 1, {8'hD5, 1'b0, 18'd0});
    add_row(ACT_DATA,   3'd4, 4'd8,  7'd64,  8'hFF, -1, '0);         // last byte closes
    add_row(ACT_HEADER, 3'd3, 4'd6,  7'd2,   8'h11, -1, '0);
    add_row(ACT_DATA,   3'd6, 4'd3,  7'd90,  8'hAA, -1, '0);
    add_row(ACT_DATA,   3'd1, 4'd12, 7'd42,  8'h55, -1, '0);
    add_row(ACT_HEADER, 3'd1, 4'd9,  7'd1,   8'h00, -1, '0);
    add_row(ACT_DATA,   3'd7, 4'd0,  7'd5,   8'h00, -1, '0);
    add_row(ACT_DATA,   3'd2, 4'd2,  7'd2,   8'h12, 0, '0);
    add_row(ACT_HEADER, 3'd2, 4'd4,  7'd3,   8'hC3, -1, '0);
    add_row(ACT_DATA,   3'd3, 4'd5,  7'd100, 8'h0F, -1, '0);
    add_row(ACT_HEADER, 3'd6, 4'd1,  7'd0,   8'h7E, -1, '0);         // empty frame drops the open one
    add_row(ACT_HEADER, 3'd4, 4'd3,  7'd2,   8'h3C, -1, '0);
    add_row(ACT_DATA,   3'd0, 4'd7,  7'd8,   8'hF0, -1, '0);
    add_row(ACT_DATA,   3'd5, 4'd11, 7'd99,  8'h81, -1, '0);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item, dir_tab[i].n_out, dir_tab[i].out_bits, n_words);
    end
    wait_for_drain();

    // random frames, a few broken or abandoned, with stray data between them
    while (live_cnt < LiveWords) begin
      no_gap = (live_cnt >= 60 && live_cnt < 130);
      if (!drained_mid && live_cnt >= 200) begin
        wait_for_drain();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        send_item(rand_item(ACT_DATA), -1, '0, n_words);
        live_cnt += (n_words != 0);
      end
      it = rand_item(ACT_HEADER);
      r  = $urandom_range(0, 99);
      if (r < 8)       it.len = '0;
      else if (r < 80) it.len = len_t'($urandom_range(1, 6));
      else if (r < 95) it.len = len_t'($urandom_range(7, 30));
      else             it.len = len_t'($urandom_range(64, 127));
      n_data = it.len;
      if (n_data > 0 && (n_data >= 64 ? $urandom_range(0, 1) == 0
                                      : $urandom_range(0, 9) == 0)) begin
        n_data = $urandom_range(0, n_data - 1);
      end
      send_item(it, -1, '0, n_words);
      live_cnt++;
      for (int k = 0; k < n_data; k++) begin
        send_item(rand_item(ACT_DATA), -1, '0, n_words);
        live_cnt++;
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && frame_exp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
